>>> rtl/core/bounded_deque_with_search_assert.svh
// Assertion macros for the bounded deque block.
// Used by the top level; no other dependencies.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`ifndef ASSERT_OFF
// condition must hold at every edge outside reset
`define BDQ_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BDQ_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define BDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/bdq_pkg.sv
// Shared types and codes for the bounded deque block.
// No dependencies; imported by bdq_cell and bounded_deque_with_search.
package bdq_pkg;

   localparam int VAL_W = 32;
   localparam int POS_W = 7;

   // operation codes
   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [2:0] FUNC_SEARCH     = 3'd4;
   localparam logic [2:0] FUNC_DUMP       = 3'd5;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

   // what every cell does in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHR,
      CELL_SHL,
      CELL_ROT,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [VAL_W-1:0]  value;
   } cell_cmd_type;

   typedef struct packed {
      logic [2:0]               func;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [VAL_W-1:0]  item_value;
      logic [POS_W-1:0]         position;
      logic                     last;
   } rsp_type;

endpackage

>>> rtl/core/bounded_deque_with_search.sv
// Push/pop front and push back: result registered next cycle.
// Pop back: count-1 rotations then a head pop; result registered from the pop.
// Search: one rotation per cycle unless rsp is stalled, one result after the full rotation.
// Dump: count result beats, one per element; walks stall while rsp is stalled.
// Reset empties the list, cells kept.
module bounded_deque_with_search
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "bounded_deque_with_search_assert.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POPB,
      S_SEARCH,
      S_DUMP
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        steps_ff, steps_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [POS_W-1:0]        match_pos_ff, match_pos_in;
   logic                    found_ff, found_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   cell_cmd_type            cmd;
   logic                    emit;
   rsp_type                 rsp_next;
   logic                    out_free;
   logic                    req_accept;
   logic                    hit_now;
   logic signed [VAL_W-1:0] cell_data [DEPTH];

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign hit_now    = !found_ff && (cell_data[0] == key_ff);

   // chain of cells, head at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_d;
      logic signed [VAL_W-1:0] right_d;
      if (i == 0) begin : g_head
         assign left_d = cmd.value;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_d = cell_data[i];
      end else begin : g_body
         assign right_d = cell_data[i+1];
      end
      bdq_cell #(
         .CELL_IDX (i),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .wrap_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   // sequencer: chain commands, result beat, next control state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      steps_in     = steps_ff;
      pos_in       = pos_ff;
      match_pos_in = match_pos_ff;
      found_in     = found_ff;
      key_in       = key_ff;
      cmd.op       = CELL_HOLD;
      cmd.value    = req_data.value;
      emit         = 1'b0;
      rsp_next.status     = STATUS_OK;
      rsp_next.item_value = '0;
      rsp_next.position   = '0;
      rsp_next.last       = 1'b1;

      case (state_ff)
         S_IDLE: if (req_accept) begin
            case (req_data.func)
               FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                  emit = 1'b1;
                  if (count_ff == CNT_FULL) begin
                     rsp_next.status = STATUS_FULL;
                  end else begin
                     cmd.op = (req_data.func == FUNC_PUSH_FRONT) ? CELL_SHR : CELL_LOAD;
                     count_in = count_ff + CNT_ONE;
                     rsp_next.item_value = req_data.value;
                  end
               end
               FUNC_POP_FRONT: begin
                  emit = 1'b1;
                  if (count_ff == '0) begin
                     rsp_next.status = STATUS_EMPTY;
                  end else begin
                     cmd.op = CELL_SHL;
                     count_in = count_ff - CNT_ONE;
                     rsp_next.item_value = cell_data[0];
                  end
               end
               FUNC_POP_BACK: begin
                  if (count_ff == '0) begin
                     emit = 1'b1;
                     rsp_next.status = STATUS_EMPTY;
                  end else begin
                     steps_in = count_ff - CNT_ONE;
                     state_in = S_POPB;
                  end
               end
               FUNC_SEARCH: begin
                  if (count_ff == '0) begin
                     emit = 1'b1;
                     rsp_next.status = STATUS_NOTFOUND;
                  end else begin
                     key_in   = req_data.value;
                     steps_in = count_ff;
                     pos_in   = POS_W'(1);
                     found_in = 1'b0;
                     state_in = S_SEARCH;
                  end
               end
               FUNC_DUMP: begin
                  if (count_ff == '0) begin
                     emit = 1'b1;
                     rsp_next.status = STATUS_EMPTY;
                  end else begin
                     steps_in = count_ff;
                     pos_in   = POS_W'(1);
                     state_in = S_DUMP;
                  end
               end
               default: ;
            endcase
         end
         // bring the back element round to the head, then pop it
         S_POPB: if (out_free) begin
            if (steps_ff != '0) begin
               cmd.op   = CELL_ROT;
               steps_in = steps_ff - CNT_ONE;
            end else begin
               cmd.op   = CELL_SHL;
               count_in = count_ff - CNT_ONE;
               emit     = 1'b1;
               rsp_next.item_value = cell_data[0];
               state_in = S_IDLE;
            end
         end
         // full rotation, comparing the head each step; order is restored at the end
         S_SEARCH: if (out_free) begin
            cmd.op   = CELL_ROT;
            steps_in = steps_ff - CNT_ONE;
            pos_in   = pos_ff + POS_W'(1);
            if (hit_now) begin
               found_in     = 1'b1;
               match_pos_in = pos_ff;
            end
            if (steps_ff == CNT_ONE) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (found_ff || hit_now) begin
                  rsp_next.item_value = key_ff;
                  rsp_next.position   = found_ff ? match_pos_ff : pos_ff;
               end else begin
                  rsp_next.status = STATUS_NOTFOUND;
               end
            end
         end
         // full rotation, one beat per element
         S_DUMP: if (out_free) begin
            cmd.op   = CELL_ROT;
            steps_in = steps_ff - CNT_ONE;
            pos_in   = pos_ff + POS_W'(1);
            emit     = 1'b1;
            rsp_next.item_value = cell_data[0];
            rsp_next.position   = pos_ff;
            rsp_next.last       = (steps_ff == CNT_ONE);
            if (steps_ff == CNT_ONE) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      steps_ff     <= steps_in;
      pos_ff       <= pos_in;
      match_pos_ff <= match_pos_in;
      found_ff     <= found_in;
      key_ff       <= key_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `BDQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_FULL, "count exceeds depth")
   `BDQ_ASSERT_ALWAYS(a_walk_steps, clock, reset, (state_ff == S_IDLE) || (steps_ff <= count_ff), "walk longer than list")
   `BDQ_ASSERT_NEXT(a_full_push, clock, reset, req_accept && (count_ff == CNT_FULL) && ((req_data.func == FUNC_PUSH_FRONT) || (req_data.func == FUNC_PUSH_BACK)), $stable(count_ff), "push into full list changed count")
   `BDQ_ASSERT_NEXT(a_walk_holds, clock, reset, (state_ff != S_IDLE) && !out_free, $stable(steps_ff) && (state_ff == $past(state_ff)), "walk advanced while result stalled")

endmodule

>>> rtl/core/bdq_cell.sv
// One storage cell of the deque chain: holds one element.
// Depends on bdq_pkg; instantiated in a row by bounded_deque_with_search.
module bdq_cell
   import bdq_pkg::*;
#(
   parameter int CELL_IDX = 0,
   parameter int CNT_W    = 7
) (
   input  logic                    clock,
   input  cell_cmd_type            cmd,
   input  logic [CNT_W-1:0]        count,
   input  logic signed [VAL_W-1:0] left_data,
   input  logic signed [VAL_W-1:0] right_data,
   input  logic signed [VAL_W-1:0] wrap_data,
   output logic signed [VAL_W-1:0] data
);

   localparam logic [CNT_W-1:0] SELF_IDX = CNT_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(CELL_IDX + 1);

   logic signed [VAL_W-1:0] data_ff;
   logic signed [VAL_W-1:0] data_in;

   // next element: neighbour, head wrap, fresh value, or the held one
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_SHR:  data_in = left_data;
         CELL_SHL:  data_in = right_data;
         CELL_ROT:  data_in = (NEXT_IDX == count) ? wrap_data : right_data;
         CELL_LOAD: if (SELF_IDX == count) begin
            data_in = cmd.value;
         end
         default:   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
